// ===== sv/cfc_pkg.sv =====
package cfc_pkg;

   // Frame layout
   localparam int unsigned PosWidth = 5;
   localparam logic [PosWidth-1:0] PosHeaderEnd = 5'd3;
   localparam logic [PosWidth-1:0] PosEuiFirst  = 5'd11;
   localparam logic [PosWidth-1:0] PosEuiLast   = 5'd18;
   localparam logic [PosWidth-1:0] PosShortMax  = 5'd18;
   localparam logic [PosWidth-1:0] PosLimit     = 5'd20;

   localparam logic [7:0] HeaderByte0   = 8'hE5;
   localparam logic [7:0] HeaderByte1   = 8'hFC;
   localparam logic [7:0] HeaderByte2   = 8'h29;
   localparam logic [7:0] BroadcastByte = 8'hFF;

   localparam logic [63:0] GatewayEuiReset = 64'h0095_6901_0000_00BB;

   typedef logic [PosWidth-1:0] pos_type;

   typedef enum logic [2:0] {
      STATUS_GATEWAY   = 3'd0,
      STATUS_BROADCAST = 3'd1,
      STATUS_MISMATCH  = 3'd2,
      STATUS_CHECKSUM  = 3'd3,
      STATUS_HEADER    = 3'd4,
      STATUS_SHORT     = 3'd5
   } status_type;

   // One received item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } item_type;

   // Tracker view handed to the top level
   typedef struct packed {
      status_type status;
      pos_type    position;
   } track_type;

   // Expected header byte at positions 0 to 2
   function automatic logic [7:0] header_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = HeaderByte0;
         2'd1:    value = HeaderByte1;
         default: value = HeaderByte2;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/cfc_tracker.sv =====
module cfc_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  cfc_pkg::item_type item,
   input  logic [63:0]       gateway_eui,
   output cfc_pkg::track_type track
);
   import cfc_pkg::*;

   pos_type    position_ff,  position_in;
   logic       header_ff,    header_in;
   logic [7:0] sum_ff,       sum_in;
   logic       gateway_ff,   gateway_in;
   logic       broadcast_ff, broadcast_in;

   logic [2:0] eui_idx;
   logic [7:0] eui_want;
   logic       in_eui;
   status_type status;

   // Pick the gateway byte for this EUI position, byte 11 is the top byte
   assign eui_idx  = 3'(PosEuiLast - position_ff);
   assign eui_want = gateway_eui[{eui_idx, 3'b000} +: 8];
   assign in_eui   = (position_ff >= PosEuiFirst) && (position_ff <= PosEuiLast);

   // Judge the frame on its last byte
   always_comb begin
      if (position_ff <= PosShortMax) begin
         status = STATUS_SHORT;
      end else if (!header_ff) begin
         status = STATUS_HEADER;
      end else if (sum_ff != item.frame_byte) begin
         status = STATUS_CHECKSUM;
      end else if (broadcast_ff) begin
         status = STATUS_BROADCAST;
      end else if (gateway_ff) begin
         status = STATUS_GATEWAY;
      end else begin
         status = STATUS_MISMATCH;
      end
   end

   // Advance the frame state on each accepted item
   always_comb begin
      position_in  = position_ff;
      header_in    = header_ff;
      sum_in       = sum_ff;
      gateway_in   = gateway_ff;
      broadcast_in = broadcast_ff;
      if (accept) begin
         if (item.last_byte) begin
            position_in  = '0;
            header_in    = 1'b1;
            sum_in       = '0;
            gateway_in   = 1'b1;
            broadcast_in = 1'b1;
         end else begin
            if (position_ff < PosHeaderEnd) begin
               if (item.frame_byte != header_byte(position_ff[1:0])) begin
                  header_in = 1'b0;
               end
            end else begin
               sum_in = sum_ff + item.frame_byte;
            end
            if (in_eui) begin
               if (item.frame_byte != BroadcastByte) begin
                  broadcast_in = 1'b0;
               end
               if (item.frame_byte != eui_want) begin
                  gateway_in = 1'b0;
               end
            end
            if (position_ff < PosLimit) begin
               position_in = position_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         header_ff    <= 1'b1;
         sum_ff       <= '0;
         gateway_ff   <= 1'b1;
         broadcast_ff <= 1'b1;
      end else begin
         position_ff  <= position_in;
         header_ff    <= header_in;
         sum_ff       <= sum_in;
         gateway_ff   <= gateway_in;
         broadcast_ff <= broadcast_in;
      end
   end

   assign track.status   = status;
   assign track.position = position_ff;

endmodule

// ===== sv/config_frame_checker.sv =====
// Channel | Dir | Signals                          | Contents
// req     | in  | req_tvalid/tready/tdata/tlast    | frame byte, tlast on checksum byte
// rsp     | out | rsp_tvalid/tready/tdata          | frame status, one per frame
// csr     | in  | csr_valid/csr_ready/csr_data     | 64-bit gateway EUI
//
// One byte a cycle unless stalled; the frame state updates at the accepting edge.
// The status of a frame is registered and shown in the cycle after its last byte.
// A held status blocks new bytes only while rsp_tready stays low.
// Synchronous active-high reset clears the frame state and loads the default EUI.
// csr_ready is always high.
module config_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] frame_status, [7:3] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);
   import cfc_pkg::*;

   logic [63:0] eui_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff;
   logic        req_accept;
   item_type    item;
   track_type   track;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign item.frame_byte = req_tdata;
   assign item.last_byte  = req_tlast;

   cfc_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .item        (item),
      .gateway_eui (eui_ff),
      .track       (track)
   );

   // Hold the gateway EUI
   always_ff @(posedge clock) begin
      if (reset) begin
         eui_ff <= GatewayEuiReset;
      end else if (csr_valid && csr_ready) begin
         eui_ff <= csr_data;
      end
   end

   // Result register: load on last byte, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         status_ff <= track.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, status_ff};

   // A last byte always produces a status next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid)
      else $error("last byte gave no status");

   // A last byte rewinds the byte position
   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> track.position == '0)
      else $error("position not rewound after frame end");

   // Position never runs past its saturation point
   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      track.position <= PosLimit)
      else $error("byte position out of range");

   // Status codes stay in the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd5)
      else $error("undefined frame status");

endmodule
